// ===== hdl/hmmd_pkg.sv =====
package hmmd_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;

    // physical layout of the shared byte memory
    localparam int MEM_ADDR_W = 16;

    // command codes
    localparam logic [1:0] CMD_READ      = 2'd0;
    localparam logic [1:0] CMD_WRITE     = 2'd1;
    localparam logic [1:0] CMD_LOAD_ROM  = 2'd2;
    localparam logic [1:0] CMD_LOAD_BOOT = 2'd3;

    // read data source codes
    localparam logic [1:0] RSEL_ZERO = 2'd0;
    localparam logic [1:0] RSEL_MEM  = 2'd1;
    localparam logic [1:0] RSEL_FF   = 2'd2;

    // bus map constants
    localparam logic [ADDR_W-1:0] ROM_END      = 16'h7FFF;
    localparam logic [ADDR_W-1:0] BOOT_LIMIT   = 16'h0100;
    localparam logic [ADDR_W-1:0] BOOT_OFF_REG = 16'hFF50;
    localparam logic [ADDR_W-1:0] ECHO_FIRST   = 16'hE000;
    localparam logic [ADDR_W-1:0] ECHO_LAST    = 16'hFDFF;
    localparam logic [ADDR_W-1:0] UNUSED_FIRST = 16'hFEA0;
    localparam logic [ADDR_W-1:0] UNUSED_LAST  = 16'hFEFF;
    localparam logic [DATA_W-1:0] OPEN_BUS     = 8'hFF;
    localparam logic [DATA_W-1:0] BOOT_OFF_VAL = 8'h01;

    // boot image lives in the physical hole left by the echo area
    localparam logic [7:0] BOOT_BASE_HI = 8'hE0;
    // echo area folds onto work ram at 0xC000
    localparam logic [2:0] WRAM_HI = 3'b110;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              prohibited;
    } rsp_t;

    typedef struct packed {
        logic [MEM_ADDR_W-1:0] phys_addr;
        logic                  rd_en;
        logic                  wr_en;
        logic [1:0]            rsel;
        logic                  prohibited;
        logic                  boot_set;
    } dec_t;

endpackage

// ===== hdl/hmmd_ram.sv =====
module hmmd_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/hmmd_decode.sv =====
module hmmd_decode (
    input  hmmd_pkg::req_t req,
    input  logic           boot_done,
    output hmmd_pkg::dec_t dec
);

    logic in_echo;
    logic in_unused;
    logic [hmmd_pkg::MEM_ADDR_W-1:0] boot_phys;
    logic [hmmd_pkg::MEM_ADDR_W-1:0] bus_phys;

    assign in_echo   = (req.addr >= hmmd_pkg::ECHO_FIRST) && (req.addr <= hmmd_pkg::ECHO_LAST);
    assign in_unused = (req.addr >= hmmd_pkg::UNUSED_FIRST)
                    && (req.addr <= hmmd_pkg::UNUSED_LAST);
    assign boot_phys = {hmmd_pkg::BOOT_BASE_HI, req.addr[7:0]};
    // everything but the echo area maps one to one
    assign bus_phys  = in_echo ? {hmmd_pkg::WRAM_HI, req.addr[12:0]} : req.addr;

    always_comb
    begin
        dec            = '0;
        dec.phys_addr  = bus_phys;
        dec.rsel       = hmmd_pkg::RSEL_ZERO;
        unique case (req.cmd)
            hmmd_pkg::CMD_READ:
            begin
                priority if (!boot_done && (req.addr < hmmd_pkg::BOOT_LIMIT))
                begin
                    dec.phys_addr = boot_phys;
                    dec.rd_en     = 1'b1;
                    dec.rsel      = hmmd_pkg::RSEL_MEM;
                end
                else if (in_unused)
                begin
                    dec.rsel = hmmd_pkg::RSEL_FF;
                end
                else
                begin
                    dec.rd_en = 1'b1;
                    dec.rsel  = hmmd_pkg::RSEL_MEM;
                end
            end
            hmmd_pkg::CMD_WRITE:
            begin
                priority if ((req.addr == hmmd_pkg::BOOT_OFF_REG)
                             && (req.wdata == hmmd_pkg::BOOT_OFF_VAL))
                begin
                    dec.boot_set = 1'b1;
                end
                else if (req.addr <= hmmd_pkg::ROM_END)
                begin
                    // rom is read only from the bus
                end
                else if (in_unused)
                begin
                    dec.prohibited = 1'b1;
                end
                else
                begin
                    dec.wr_en = 1'b1;
                end
            end
            hmmd_pkg::CMD_LOAD_ROM:
            begin
                dec.phys_addr = req.addr;
                dec.wr_en     = (req.addr <= hmmd_pkg::ROM_END);
            end
            hmmd_pkg::CMD_LOAD_BOOT:
            begin
                dec.phys_addr = boot_phys;
                dec.wr_en     = (req.addr < hmmd_pkg::BOOT_LIMIT);
            end
        endcase
    end

endmodule

// ===== hdl/handheld_memory_map_decoder.sv =====
// Memory map decoder for a handheld console CPU bus without a bank controller.
// Each request is a bus read, a bus write, or a one-byte load into the
// cartridge ROM or the boot ROM image, and each gives exactly one response.
// All byte stores (cartridge ROM, video RAM, external RAM, work RAM and its
// echo, sprite RAM, I/O registers, high RAM, interrupt enable and the boot
// image) share one 64 KiB single-port memory with a registered read port; the
// boot image sits in the physical hole behind the echo area. A request is
// taken every cycle unless the block is clearing or a stalled response holds
// off new requests, and its response appears on the next cycle, set by the one
// memory access per request. After reset a clearing pass writes zero to all
// 65536 memory bytes, one per cycle, and req_stall stays high until it ends.
// Writing 1 to 0xFF50 turns the boot overlay off until the next reset.
module handheld_memory_map_decoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  hmmd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output hmmd_pkg::rsp_t rsp
);

    // clearing pass state
    logic                            clearing_reg;
    logic                            clearing_next;
    logic [hmmd_pkg::MEM_ADDR_W-1:0] clr_addr_reg;
    logic [hmmd_pkg::MEM_ADDR_W-1:0] clr_addr_next;

    // boot overlay flag
    logic boot_done_reg;
    logic boot_done_next;

    // response stage
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic [1:0] rsel_reg;
    logic [1:0] rsel_next;
    logic       prohibited_reg;
    logic       prohibited_next;

    hmmd_pkg::dec_t dec;
    logic           accept;

    // memory port
    logic                            mem_en;
    logic                            mem_we;
    logic [hmmd_pkg::MEM_ADDR_W-1:0] mem_addr;
    logic [hmmd_pkg::DATA_W-1:0]     mem_wdata;
    logic [hmmd_pkg::DATA_W-1:0]     mem_rdata;

    hmmd_decode u_decode (
        .req       (req),
        .boot_done (boot_done_reg),
        .dec       (dec)
    );

    // take a request unless clearing or the response stage is stuck
    assign req_stall = clearing_reg || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    // clearing pass owns the port; otherwise one access per request
    always_comb
    begin
        if (clearing_reg)
        begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_addr  = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_en    = accept && (dec.rd_en || dec.wr_en);
            mem_we    = dec.wr_en;
            mem_addr  = dec.phys_addr;
            mem_wdata = req.wdata;
        end
    end

    hmmd_ram #(
        .ADDR_W (hmmd_pkg::MEM_ADDR_W),
        .DATA_W (hmmd_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        clearing_next   = clearing_reg;
        clr_addr_next   = clr_addr_reg;
        boot_done_next  = boot_done_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsel_next       = rsel_reg;
        prohibited_next = prohibited_reg;

        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clearing_next = 1'b0;
            end
        end

        // response leaves when taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (accept)
        begin
            rsp_valid_next  = 1'b1;
            rsel_next       = dec.rsel;
            prohibited_next = dec.prohibited;
            if (dec.boot_set)
            begin
                boot_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            boot_done_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsel_reg       <= hmmd_pkg::RSEL_ZERO;
            prohibited_reg <= 1'b0;
        end
        else
        begin
            clearing_reg   <= clearing_next;
            clr_addr_reg   <= clr_addr_next;
            boot_done_reg  <= boot_done_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsel_reg       <= rsel_next;
            prohibited_reg <= prohibited_next;
        end
    end

    // read data comes straight from the memory output register, which only
    // reloads on an accepted read, so it holds while the response is stalled
    always_comb
    begin
        rsp.prohibited = prohibited_reg;
        unique case (rsel_reg)
            hmmd_pkg::RSEL_MEM: rsp.rdata = mem_rdata;
            hmmd_pkg::RSEL_FF:  rsp.rdata = hmmd_pkg::OPEN_BUS;
            default:            rsp.rdata = '0;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== hdl/hmmd_checker.sv =====
module hmmd_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input hmmd_pkg::rsp_t rsp
);

    // stalled response keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // every accepted request has a response on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("accepted request gave no response");

    // a taken response is not repeated without a new request
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall && !(req_valid && !req_stall) |=> !rsp_valid)
        else $error("response repeated");

    // a blocked response holds off new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("request taken over a blocked response");

    // a prohibited write returns no data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.prohibited |-> rsp.rdata == '0)
        else $error("prohibited write returned data");

endmodule

bind handheld_memory_map_decoder hmmd_checker u_hmmd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import hmmd_pkg::*;

    // run length and the cycle limit; the block clears its 64 KiB store after
    // reset before it takes the first request
    localparam int RANDOM_REQS  = 1000;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 20;
    localparam int SHOWN_ERRORS = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // requests waiting to be offered, and responses the decoder owes us
    req_t req_backlog[$];
    rsp_t expected_rsp[$];
    rsp_t next_exp;

    int total_reqs = 0;
    int req_count = 0;
    int errors = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // shadow copy of every byte store; two-state so all of it starts at zero
    bit [7:0] rom_img [32768];
    bit [7:0] boot_img [256];
    bit [7:0] vram_img [8192];
    bit [7:0] eram_img [8192];
    bit [7:0] wram_img [8192];
    bit [7:0] oam_img [160];
    bit [7:0] io_img [128];
    bit [7:0] hram_img [127];
    bit [7:0] ie_img;
    bit       boot_off;

    handheld_memory_map_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // apply one request to the shadow memories and return the response it earns
    function automatic rsp_t predict_bus(req_t r);
        rsp_t res;
        logic [15:0] a;
        logic [7:0] v;
        res = '0;
        a = r.addr;
        v = r.wdata;
        case (r.cmd)
            CMD_READ:
            begin
                // boot overlay wins below 0x100 until it is switched off
                if (!boot_off && a < BOOT_LIMIT)
                    res.rdata = boot_img[a[7:0]];
                else if (a <= ROM_END)
                    res.rdata = rom_img[a[14:0]];
                else if (a <= 16'h9FFF)
                    res.rdata = vram_img[a[12:0]];
                else if (a <= 16'hBFFF)
                    res.rdata = eram_img[a[12:0]];
                else if (a <= ECHO_LAST)
                    res.rdata = wram_img[a[12:0]];   // work ram and its echo
                else if (a < UNUSED_FIRST)
                    res.rdata = oam_img[a[7:0]];
                else if (a <= UNUSED_LAST)
                    res.rdata = OPEN_BUS;
                else if (a <= 16'hFF7F)
                    res.rdata = io_img[a[6:0]];
                else if (a <= 16'hFFFE)
                    res.rdata = hram_img[a[6:0]];
                else
                    res.rdata = ie_img;
            end
            CMD_WRITE:
            begin
                // writing 1 to the boot-off register stores nothing
                if (a == BOOT_OFF_REG && v == BOOT_OFF_VAL)
                    boot_off = 1'b1;
                else if (a <= ROM_END)
                    ;                                // rom is read-only on the bus
                else if (a <= 16'h9FFF)
                    vram_img[a[12:0]] = v;
                else if (a <= 16'hBFFF)
                    eram_img[a[12:0]] = v;
                else if (a <= ECHO_LAST)
                    wram_img[a[12:0]] = v;
                else if (a < UNUSED_FIRST)
                    oam_img[a[7:0]] = v;
                else if (a <= UNUSED_LAST)
                    res.prohibited = 1'b1;
                else if (a <= 16'hFF7F)
                    io_img[a[6:0]] = v;
                else if (a <= 16'hFFFE)
                    hram_img[a[6:0]] = v;
                else
                    ie_img = v;
            end
            CMD_LOAD_ROM:
            begin
                if (a <= ROM_END)
                    rom_img[a[14:0]] = v;
            end
            default:
            begin
                if (a < BOOT_LIMIT)
                    boot_img[a[7:0]] = v;
            end
        endcase
        return res;
    endfunction

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // three idling phases, by how far through the requests we are
    function automatic int phase_of(int n);
        if (n < total_reqs / 3)
            return 0;
        else if (n < 2 * total_reqs / 3)
            return 1;
        return 2;
    endfunction

    // address inside a region: mostly its first or last 16 bytes so that
    // reads land on bytes written earlier, sometimes anywhere in it
    function automatic logic [15:0] pick_in(int base, int span);
        int mode;
        mode = $urandom_range(0, 3);
        if (mode < 2)
            return 16'(base + $urandom_range(0, 15));
        else if (mode == 2)
            return 16'(base + span - 1 - $urandom_range(0, 15));
        return 16'(base + $urandom_range(0, span - 1));
    endfunction

    function automatic logic [15:0] pick_bus_addr();
        case ($urandom_range(0, 12))
            0:       return pick_in(16'h0000, 256);      // boot overlay window
            1:       return pick_in(16'h0000, 32768);    // cartridge rom
            2:       return pick_in(16'h8000, 8192);     // video ram
            3:       return pick_in(16'hA000, 8192);     // external ram
            4:       return pick_in(16'hC000, 8192);     // work ram
            5:       return pick_in(16'hE000, 7680);     // echo of work ram
            6:       return pick_in(16'hFE00, 160);      // sprite ram
            7:       return pick_in(16'hFEA0, 96);       // unusable area
            8:       return pick_in(16'hFF00, 128);      // io registers
            9:       return BOOT_OFF_REG;
            10:      return pick_in(16'hFF80, 127);      // high ram
            11:      return 16'hFFFF;                    // interrupt enable
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic req_t random_req(int idx);
        req_t r;
        int pick;
        r.wdata = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            r.cmd = CMD_READ;
            r.addr = pick_bus_addr();
        end
        else if (pick < 75)
        begin
            r.cmd = CMD_WRITE;
            r.addr = pick_bus_addr();
            // boot overlay stays on for the first half, then may go off
            if (r.addr == BOOT_OFF_REG)
            begin
                if (idx < RANDOM_REQS / 2)
                    r.wdata = (r.wdata == BOOT_OFF_VAL) ? 8'h00 : r.wdata;
                else if (chance(30))
                    r.wdata = BOOT_OFF_VAL;
            end
        end
        else if (pick < 87)
        begin
            r.cmd = CMD_LOAD_ROM;
            r.addr = chance(90) ? pick_in(16'h0000, 32768)
                                : 16'($urandom_range(32768, 65535));
        end
        else
        begin
            r.cmd = CMD_LOAD_BOOT;
            r.addr = chance(90) ? 16'($urandom_range(0, 255))
                                : 16'($urandom_range(256, 65535));
        end
        // halfway through, the boot overlay is switched off for sure
        if (idx == RANDOM_REQS / 2)
        begin
            r.cmd = CMD_WRITE;
            r.addr = BOOT_OFF_REG;
            r.wdata = BOOT_OFF_VAL;
        end
        return r;
    endfunction

    task automatic queue_req(logic [1:0] c, logic [15:0] a, logic [7:0] d);
        req_t r;
        r.cmd = c;
        r.addr = a;
        r.wdata = d;
        req_backlog.push_back(r);
    endtask

    task automatic report_bad(string what, rsp_t exp_r, rsp_t got_r);
        errors++;
        if (errors <= SHOWN_ERRORS)
            $display("%0t: %s: expected rdata %02h prohibited %0b, got rdata %02h prohibited %0b",
                     $time, what, exp_r.rdata, exp_r.prohibited, got_r.rdata, got_r.prohibited);
    endtask

    // request driver: a new request goes out only once the current one is taken,
    // so a stalled payload never moves; prediction happens on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            req_count <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp.push_back(predict_bus(req));
                req_count <= req_count + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (req_backlog.size() != 0 &&
                    !(phase_of(req_count) == 0 && chance(22)) &&
                    !(phase_of(req_count) == 1 && chance(80)))
                begin
                    req <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off during the no-idle phase; the sender keeps
    // offering requests so the decoder backs up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && req_count >= 2 * total_reqs / 3 + 40)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // response monitor: checks each taken response against the oldest
    // expectation, then picks the stall for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                    report_bad("response with no request outstanding", '0, rsp);
                else
                begin
                    next_exp = expected_rsp.pop_front();
                    if (rsp.rdata !== next_exp.rdata)
                        report_bad("rdata mismatch", next_exp, rsp);
                    else if (rsp.prohibited !== next_exp.prohibited)
                        report_bad("prohibited mismatch", next_exp, rsp);
                end
            end
            rsp_stall <= (hold_left != 0) ||
                         (phase_of(req_count) == 0 && chance(80)) ||
                         (phase_of(req_count) == 1 && chance(22));
        end
    end

    // hard stop; the limit covers the clearing pass many times over
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        // directed requests: overlay reads, loads at and past the ends,
        // ignored rom writes, echo aliasing, unusable area, ends of several regions
        queue_req(CMD_READ,      16'h0000, 8'h00);
        queue_req(CMD_LOAD_BOOT, 16'h0000, 8'hA5);
        queue_req(CMD_LOAD_BOOT, 16'h00FF, 8'h5A);
        queue_req(CMD_LOAD_BOOT, 16'h0100, 8'h77);   // past the boot image, dropped
        queue_req(CMD_LOAD_BOOT, 16'hFFFF, 8'h11);
        queue_req(CMD_LOAD_ROM,  16'h0000, 8'h3C);
        queue_req(CMD_LOAD_ROM,  16'h7FFF, 8'hC3);
        queue_req(CMD_LOAD_ROM,  16'h8000, 8'h99);   // past the rom, dropped
        queue_req(CMD_WRITE,     16'h0000, 8'hEE);   // rom write ignored
        queue_req(CMD_READ,      16'h0000, 8'h00);
        queue_req(CMD_READ,      16'h00FF, 8'h00);
        queue_req(CMD_READ,      16'h0100, 8'h00);
        queue_req(CMD_READ,      16'h7FFF, 8'h00);
        queue_req(CMD_WRITE,     16'hC000, 8'h12);
        queue_req(CMD_READ,      16'hE000, 8'h00);   // echo of work ram
        queue_req(CMD_WRITE,     16'hFDFF, 8'hFF);
        queue_req(CMD_READ,      16'hDDFF, 8'h00);
        queue_req(CMD_WRITE,     16'hFEA0, 8'hFF);   // unusable area, flagged
        queue_req(CMD_READ,      16'hFEFF, 8'h00);
        queue_req(CMD_WRITE,     16'hFE9F, 8'h80);
        queue_req(CMD_WRITE,     16'hFF50, 8'h02);   // not 1, so a plain io store
        queue_req(CMD_READ,      16'hFF50, 8'h00);
        queue_req(CMD_WRITE,     16'hFFFF, 8'h01);
        queue_req(CMD_WRITE,     16'h9FFF, 8'h7E);
        queue_req(CMD_READ,      16'hFFFF, 8'h00);
        for (int i = 0; i < RANDOM_REQS; i++)
            req_backlog.push_back(random_req(i));
        total_reqs = req_backlog.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_valid)
            @(posedge clk);
        for (int i = 0; i < DRAIN_LIMIT && expected_rsp.size() != 0; i++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            errors++;
            $display("%0d responses never arrived", expected_rsp.size());
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
